// ===== rtl/cfsi_pkg.sv =====
// shared types and constants of the chroma fire streak injector
package cfsi_pkg;

  // shared unit word and multiplier operand widths
  localparam int ALU_W = 36;
  localparam int MUL_W = 18;

  typedef logic signed [ALU_W-1:0] alu_word_t;

  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_ADD = 2'd1,
    ALU_SUB = 2'd2
  } alu_op_t;

  typedef struct packed {
    alu_op_t   op;
    alu_word_t a;
    alu_word_t b;
  } alu_req_t;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANDOMIZATION = 1'd1;
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 16'd1573;
  localparam logic [CFG_DATA_W-1:0] RANDOMIZATION_RESET = 16'd66;

  // streak constants
  localparam logic [7:0] MIN_STEP = 8'd12;
  localparam logic signed [9:0] FIRST_GAIN = 10'sd18;
  localparam logic [15:0] STEP_SPAN = 16'd126;
  localparam int STEP_FRAC_W = 16;
  localparam logic [15:0] BLUE_LIMIT = 16'd16384;
  localparam logic [16:0] JITTER_BASE = 17'd32768;
  localparam int EDGE_SHIFT = 7;

  // fire: only floor(num / (512 * den)) matters, found one quotient bit a step
  localparam logic [17:0] FIRE_BASE = 18'd163840;
  localparam int FIRE_FRAC_SHIFT = 9;
  localparam int QUOT_W = 9;
  localparam int CNT_W = 4;

endpackage

// ===== rtl/cfsi_if.sv =====
// request channels of the chroma fire streak injector
interface cfsi_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  column;
  logic [31:0] luma_quad;
  logic [7:0]  cb_in;
  logic [7:0]  cr_in;
  logic [15:0] rnd_step;
  logic [15:0] rnd_thresh;
  logic [15:0] rnd_edge;
  logic [15:0] rnd_noise;
  logic [15:0] rnd_color;
  logic [15:0] rnd_fire;

  modport source (
    output valid, column, luma_quad, cb_in, cr_in, rnd_step, rnd_thresh,
           rnd_edge, rnd_noise, rnd_color, rnd_fire,
    input  ready
  );
  modport sink (
    input  valid, column, luma_quad, cb_in, cr_in, rnd_step, rnd_thresh,
           rnd_edge, rnd_noise, rnd_color, rnd_fire,
    output ready
  );
endinterface

interface cfsi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cb_out;
  logic [7:0] cr_out;
  logic       streak_active;

  modport source (output valid, cb_out, cr_out, streak_active, input ready);
  modport sink (input valid, cb_out, cr_out, streak_active, output ready);
endinterface

// ===== rtl/cfsi_alu.sv =====
// shared multiply, add and subtract unit
module cfsi_alu (
  input  cfsi_pkg::alu_req_t  req,
  output cfsi_pkg::alu_word_t result
);

  logic signed [cfsi_pkg::MUL_W-1:0]   ma;
  logic signed [cfsi_pkg::MUL_W-1:0]   mb;
  logic signed [2*cfsi_pkg::MUL_W-1:0] prod;

  assign ma = req.a[cfsi_pkg::MUL_W-1:0];
  assign mb = req.b[cfsi_pkg::MUL_W-1:0];
  assign prod = ma * mb;

  always_comb begin
    case (req.op)
      cfsi_pkg::ALU_MUL: result = cfsi_pkg::ALU_W'(prod);
      cfsi_pkg::ALU_ADD: result = req.a + req.b;
      cfsi_pkg::ALU_SUB: result = req.a - req.b;
      default:           result = '0;
    endcase
  end

endmodule

// ===== rtl/chroma_fire_streak_injector.sv =====
// chroma fire streak injector: sequencer around one shared arithmetic unit
// steps with a live streak: six unit products and sums, a decision state,
//   nine divide steps, fire and emit; when the cell passes through, emit
//   follows the decision state directly
// one request at a time: a new one is taken in idle, after emit fills the output slot
// reset: synchronous; clears streak state and loads threshold 1573, noise 66
module chroma_fire_streak_injector #(
  parameter int LINE_CELLS = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  cfsi_in_if.sink                          cell_in,
  cfsi_out_if.source                       cell_out,
  input  logic                             cfg_wr_en,
  input  logic [cfsi_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cfsi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_MUL_EDGE  = 11'b000_0000_0010,
    S_MUL_NOISE = 11'b000_0000_0100,
    S_ADD       = 11'b000_0000_1000,
    S_MUL_THR   = 11'b000_0001_0000,
    S_CMP       = 11'b000_0010_0000,
    S_MUL_STEP  = 11'b000_0100_0000,
    S_DECIDE    = 11'b000_1000_0000,
    S_DIV       = 11'b001_0000_0000,
    S_FIRE      = 11'b010_0000_0000,
    S_EMIT      = 11'b100_0000_0000
  } state_t;

  state_t state;

  logic [cfsi_pkg::CFG_DATA_W-1:0] threshold;
  logic [cfsi_pkg::CFG_DATA_W-1:0] randomization;

  logic [7:0] streak_start;
  logic       streak_valid;
  logic       streak_blue;

  // latched request
  logic [7:0]  col;
  logic [31:0] luma;
  logic [7:0]  cb;
  logic [7:0]  cr;
  logic [15:0] rs;
  logic [15:0] rt;
  logic [15:0] re;
  logic [15:0] rn;
  logic [15:0] rc;
  logic [15:0] rf;

  // working registers
  cfsi_pkg::alu_word_t acc;
  cfsi_pkg::alu_word_t tmp;
  cfsi_pkg::alu_word_t rem;
  cfsi_pkg::alu_word_t dsh;
  logic                      pass;
  logic [7:0]                hs;
  logic [cfsi_pkg::QUOT_W-1:0] quot;
  logic [cfsi_pkg::CNT_W-1:0]  cnt;

  logic [7:0] res_cb;
  logic [7:0] res_cr;
  logic       res_active;

  logic       out_valid;
  logic [7:0] out_cb;
  logic [7:0] out_cr;
  logic       out_active;

  cfsi_pkg::alu_req_t  alu_req;
  cfsi_pkg::alu_word_t alu_res;

  logic signed [10:0] delta;
  logic signed [9:0]  gain;
  logic               start;
  logic [8:0]         den;
  logic [8:0]         add;
  logic [7:0]         chan;
  logic [9:0]         chan_sum;
  logic [7:0]         chan_sat;

  cfsi_alu u_alu (
    .req    (alu_req),
    .result (alu_res)
  );

  // luma edge term: difference of the pair sums of the two halves
  assign delta = $signed({3'b000, luma[7:0]}) + $signed({3'b000, luma[15:8]})
               - $signed({3'b000, luma[23:16]}) - $signed({3'b000, luma[31:24]});

  assign gain = streak_valid ? ($signed({2'b00, col}) - $signed({2'b00, streak_start}))
                             : cfsi_pkg::FIRST_GAIN;
  assign start = pass && (gain > $signed({2'b00, hs}));
  assign den = 9'(gain + 10'sd1);

  assign add = quot - 9'd1;
  assign chan = streak_blue ? cb : cr;
  assign chan_sum = {2'b00, chan} + {1'b0, add};
  assign chan_sat = (chan_sum > 10'd255) ? 8'hFF : chan_sum[7:0];

  always_comb begin
    alu_req.op = cfsi_pkg::ALU_SUB;
    alu_req.a = '0;
    alu_req.b = '0;
    case (state)
      S_MUL_EDGE: begin
        alu_req.op = cfsi_pkg::ALU_MUL;
        alu_req.a = cfsi_pkg::ALU_W'(delta);
        alu_req.b = cfsi_pkg::ALU_W'(re);
      end
      S_MUL_NOISE: begin
        alu_req.op = cfsi_pkg::ALU_MUL;
        alu_req.a = cfsi_pkg::ALU_W'(randomization);
        alu_req.b = cfsi_pkg::ALU_W'(rn);
      end
      S_ADD: begin
        alu_req.op = cfsi_pkg::ALU_ADD;
        alu_req.a = acc;
        alu_req.b = tmp;
      end
      S_MUL_THR: begin
        alu_req.op = cfsi_pkg::ALU_MUL;
        alu_req.a = cfsi_pkg::ALU_W'(threshold);
        alu_req.b = cfsi_pkg::ALU_W'(cfsi_pkg::JITTER_BASE + {1'b0, rt});
      end
      S_CMP: begin
        alu_req.op = cfsi_pkg::ALU_SUB;
        alu_req.a = tmp;
        alu_req.b = acc;
      end
      S_MUL_STEP: begin
        alu_req.op = cfsi_pkg::ALU_MUL;
        alu_req.a = cfsi_pkg::ALU_W'(rs);
        alu_req.b = cfsi_pkg::ALU_W'(cfsi_pkg::STEP_SPAN);
      end
      S_DIV: begin
        alu_req.op = cfsi_pkg::ALU_SUB;
        alu_req.a = rem;
        alu_req.b = dsh;
      end
      default: begin
        alu_req.op = cfsi_pkg::ALU_SUB;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      threshold <= cfsi_pkg::THRESHOLD_RESET;
      randomization <= cfsi_pkg::RANDOMIZATION_RESET;
      streak_start <= '0;
      streak_valid <= 1'b0;
      streak_blue <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          cfsi_pkg::REG_THRESHOLD:     threshold <= cfg_wdata;
          cfsi_pkg::REG_RANDOMIZATION: randomization <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid && cell_out.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cell_in.valid) begin
            col <= cell_in.column;
            luma <= cell_in.luma_quad;
            cb <= cell_in.cb_in;
            cr <= cell_in.cr_in;
            rs <= cell_in.rnd_step;
            rt <= cell_in.rnd_thresh;
            re <= cell_in.rnd_edge;
            rn <= cell_in.rnd_noise;
            rc <= cell_in.rnd_color;
            rf <= cell_in.rnd_fire;
            state <= S_MUL_EDGE;
          end
        end
        S_MUL_EDGE: begin
          acc <= alu_res <<< cfsi_pkg::EDGE_SHIFT;
          state <= S_MUL_NOISE;
        end
        S_MUL_NOISE: begin
          tmp <= alu_res;
          state <= S_ADD;
        end
        S_ADD: begin
          acc <= alu_res;
          state <= S_MUL_THR;
        end
        S_MUL_THR: begin
          tmp <= alu_res;
          state <= S_CMP;
        end
        S_CMP: begin
          // edge plus noise term beats the jittered threshold when threshold - term < 0
          pass <= alu_res[cfsi_pkg::ALU_W-1];
          state <= S_MUL_STEP;
        end
        S_MUL_STEP: begin
          hs <= cfsi_pkg::MIN_STEP + {1'b0, alu_res[cfsi_pkg::STEP_FRAC_W +: 7]};
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          res_cb <= cb;
          res_cr <= cr;
          res_active <= 1'b0;
          state <= S_EMIT;
          if (col == 8'd0) begin
            streak_valid <= 1'b0;
          end else if (int'(col) < LINE_CELLS) begin
            if (start) begin
              streak_start <= col;
              streak_valid <= 1'b1;
              streak_blue <= (rc <= cfsi_pkg::BLUE_LIMIT);
            end
            if (streak_valid || start) begin
              if (gain < 10'sd0) begin
                // start lies beyond this cell's column: streak ends
                streak_valid <= 1'b0;
              end else begin
                rem <= cfsi_pkg::ALU_W'(cfsi_pkg::FIRE_BASE + {2'b00, rf});
                dsh <= cfsi_pkg::ALU_W'(den)
                       << (cfsi_pkg::FIRE_FRAC_SHIFT + cfsi_pkg::QUOT_W - 1);
                quot <= '0;
                cnt <= cfsi_pkg::CNT_W'(cfsi_pkg::QUOT_W - 1);
                state <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          if (!alu_res[cfsi_pkg::ALU_W-1]) begin
            rem <= alu_res;
          end
          quot <= {quot[cfsi_pkg::QUOT_W-2:0], ~alu_res[cfsi_pkg::ALU_W-1]};
          dsh <= dsh >>> 1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_FIRE;
          end
        end
        S_FIRE: begin
          if (quot == '0) begin
            // negative fire ends the streak
            streak_valid <= 1'b0;
          end else begin
            res_active <= 1'b1;
            if (streak_blue) begin
              res_cb <= chan_sat;
            end else begin
              res_cr <= chan_sat;
            end
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || cell_out.ready) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload, loaded when the output slot is free
  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && (!out_valid || cell_out.ready)) begin
      out_cb <= res_cb;
      out_cr <= res_cr;
      out_active <= res_active;
    end
  end

  assign cell_in.ready = (state == S_IDLE);
  assign cell_out.valid = out_valid;
  assign cell_out.cb_out = out_cb;
  assign cell_out.cr_out = out_cr;
  assign cell_out.streak_active = out_active;

endmodule
